>>> rtl/core/tdi_pkg.sv
package tdi_pkg;

    // one stored track point
    typedef struct packed {
        logic [31:0]        tm;
        logic signed [29:0] lat;
        logic signed [30:0] lon;
    } tdi_entry_t;

    // operands handed from the scan to the arithmetic unit
    typedef struct packed {
        logic signed [29:0] a_lat;
        logic signed [29:0] b_lat;
        logic signed [29:0] q_lat;
        logic signed [30:0] a_lon;
        logic signed [30:0] b_lon;
        logic signed [30:0] q_lon;
        logic [31:0]        off;
        logic [31:0]        span;
    } tdi_job_t;

    localparam logic [30:0] DEV_MAX = 31'h7FFF_FFFF;

endpackage

>>> rtl/core/tdi_track_mem.sv
module tdi_track_mem
    import tdi_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
)(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  tdi_entry_t    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output tdi_entry_t    rd_data
);

    tdi_entry_t mem [DEPTH];
    tdi_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/tdi_math.sv
module tdi_math
    import tdi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  tdi_job_t    job,
    output logic        done,
    output logic [30:0] dev
);

    localparam logic [2:0] P_IDLE = 3'd0;
    localparam logic [2:0] P_MUL  = 3'd1;
    localparam logic [2:0] P_DIV  = 3'd2;
    localparam logic [2:0] P_DIFF = 3'd3;
    localparam logic [2:0] P_SQ   = 3'd4;
    localparam logic [2:0] P_SUM  = 3'd5;
    localparam logic [2:0] P_ROOT = 3'd6;

    logic [2:0]  phase_reg;
    logic [5:0]  cnt_reg;
    logic        done_reg;
    tdi_job_t    job_reg;
    logic [31:0] mlat_reg, mlon_reg;
    logic        nlat_reg, nlon_reg;
    logic [31:0] off_reg;
    logic [63:0] plat_reg, plon_reg;   // product, then quotient
    logic [31:0] rlat_reg, rlon_reg;   // division remainders
    logic [31:0] dx_reg, dy_reg;
    logic [63:0] sx_reg, sy_reg;
    logic [63:0] n_reg;
    logic [31:0] root_reg;
    logic [33:0] srem_reg;

    logic [31:0] dlat, dlon;
    logic [32:0] trl, trn;
    logic [33:0] vlat, vlon, dxs, dys;
    logic [35:0] strial, stv;

    always_comb
    begin
        dlat = {{2{job.b_lat[29]}}, job.b_lat} - {{2{job.a_lat[29]}}, job.a_lat};
        dlon = {job.b_lon[30], job.b_lon} - {job.a_lon[30], job.a_lon};
        trl  = {rlat_reg, plat_reg[63]};
        trn  = {rlon_reg, plon_reg[63]};
        vlat = {{4{job_reg.a_lat[29]}}, job_reg.a_lat}
             + (nlat_reg ? -{2'b00, plat_reg[31:0]} : {2'b00, plat_reg[31:0]});
        vlon = {{3{job_reg.a_lon[30]}}, job_reg.a_lon}
             + (nlon_reg ? -{2'b00, plon_reg[31:0]} : {2'b00, plon_reg[31:0]});
        dxs  = {{4{job_reg.q_lat[29]}}, job_reg.q_lat} - vlat;
        dys  = {{3{job_reg.q_lon[30]}}, job_reg.q_lon} - vlon;
        strial = {srem_reg, n_reg[63:62]};
        stv    = {2'b00, root_reg, 2'b01};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            // root settles on the last iteration
            done_reg <= (phase_reg == P_ROOT) && (cnt_reg == 6'd31);
            case (phase_reg)
                P_IDLE:
                begin
                    if (start)
                    begin
                        phase_reg <= P_MUL;
                        cnt_reg   <= '0;
                    end
                end
                P_MUL:
                begin
                    if (cnt_reg == 6'd31)
                    begin
                        phase_reg <= P_DIV;
                        cnt_reg   <= '0;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 6'd1;
                    end
                end
                P_DIV:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd63)
                    begin
                        phase_reg <= P_DIFF;
                    end
                end
                P_DIFF: phase_reg <= P_SQ;
                P_SQ:   phase_reg <= P_SUM;
                P_SUM:
                begin
                    phase_reg <= P_ROOT;
                    cnt_reg   <= '0;
                end
                P_ROOT:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd31)
                    begin
                        phase_reg <= P_IDLE;
                    end
                end
                default: phase_reg <= P_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (phase_reg)
            P_IDLE:
            begin
                if (start)
                begin
                    job_reg  <= job;
                    nlat_reg <= dlat[31];
                    nlon_reg <= dlon[31];
                    mlat_reg <= dlat[31] ? -dlat : dlat;
                    mlon_reg <= dlon[31] ? -dlon : dlon;
                    off_reg  <= job.off;
                    plat_reg <= '0;
                    plon_reg <= '0;
                    rlat_reg <= '0;
                    rlon_reg <= '0;
                end
            end
            P_MUL:
            begin
                plat_reg <= {plat_reg[62:0], 1'b0} + (off_reg[31] ? {32'd0, mlat_reg} : 64'd0);
                plon_reg <= {plon_reg[62:0], 1'b0} + (off_reg[31] ? {32'd0, mlon_reg} : 64'd0);
                off_reg  <= {off_reg[30:0], 1'b0};
            end
            P_DIV:
            begin
                if (trl >= {1'b0, job_reg.span})
                begin
                    rlat_reg <= 32'(trl - {1'b0, job_reg.span});
                    plat_reg <= {plat_reg[62:0], 1'b1};
                end
                else
                begin
                    rlat_reg <= trl[31:0];
                    plat_reg <= {plat_reg[62:0], 1'b0};
                end
                if (trn >= {1'b0, job_reg.span})
                begin
                    rlon_reg <= 32'(trn - {1'b0, job_reg.span});
                    plon_reg <= {plon_reg[62:0], 1'b1};
                end
                else
                begin
                    rlon_reg <= trn[31:0];
                    plon_reg <= {plon_reg[62:0], 1'b0};
                end
            end
            P_DIFF:
            begin
                dx_reg <= dxs[33] ? 32'(-dxs) : dxs[31:0];
                dy_reg <= dys[33] ? 32'(-dys) : dys[31:0];
            end
            P_SQ:
            begin
                sx_reg <= dx_reg * dx_reg;
                sy_reg <= dy_reg * dy_reg;
            end
            P_SUM:
            begin
                n_reg    <= sx_reg + sy_reg;
                root_reg <= '0;
                srem_reg <= '0;
            end
            P_ROOT:
            begin
                n_reg <= {n_reg[61:0], 2'b00};
                if (strial >= stv)
                begin
                    srem_reg <= 34'(strial - stv);
                    root_reg <= {root_reg[30:0], 1'b1};
                end
                else
                begin
                    srem_reg <= strial[33:0];
                    root_reg <= {root_reg[30:0], 1'b0};
                end
            end
            default: ;
        endcase
    end

    assign done = done_reg;
    assign dev  = root_reg[31] ? DEV_MAX : root_reg[30:0];

endmodule

>>> rtl/core/track_deviation_interpolator.sv
// channel | direction | handshake            | word
// in      | to block  | in_valid / in_stall   | kind, time_req, latitude, longitude
// out     | from block| out_valid / out_stall | deviation, found
//
// A query scans stored points one a cycle through the table memory, then the
// arithmetic unit runs a serial multiply, a restoring divide and a bit-pair
// square root.
// Reset clears counts and bases; the table needs no clearing.
// The next word is taken while a result still waits on a stalled output.
module track_deviation_interpolator
    import tdi_pkg::*;
#(
    parameter int TRACK_DEPTH = 1024
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [31:0] time_req,
    input  logic signed [29:0] latitude,
    input  logic signed [30:0] longitude,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [30:0] deviation,
    output logic        found
);

    localparam int AW = (TRACK_DEPTH > 1) ? $clog2(TRACK_DEPTH) : 1;
    localparam int CW = $clog2(TRACK_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TRACK_DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_MATH = 3'd2;
    localparam logic [2:0] S_RES  = 3'd3;

    logic [2:0]    state_reg;
    logic [CW-1:0] count_reg, issue_reg, eval_reg;
    logic          rvalid_reg;
    logic [31:0]   tbase_reg, qbase_reg, t_reg;
    logic          qseen_reg;
    logic signed [29:0] qlat_reg;
    logic signed [30:0] qlon_reg;
    tdi_entry_t    prev_reg;
    logic          res_found_reg;
    logic [30:0]   res_dev_reg;
    logic          out_valid_reg, found_reg;
    logic [30:0]   dev_reg;
    tdi_job_t      job_reg;
    logic          start_reg;

    logic          acc, wr_en, rd_en;
    tdi_entry_t    wr_data, rd_data;
    logic          math_done;
    logic [30:0]   math_dev;
    logic [32:0]   off_w, span_w;
    logic          is_exact, is_bracket, out_free;

    assign acc   = in_valid && !in_stall;
    assign wr_en = acc && !kind && (count_reg != DEPTH_C);
    assign rd_en = (state_reg == S_SCAN) && (issue_reg < count_reg);
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        wr_data.tm  = (count_reg == '0) ? 32'd0 : time_req - tbase_reg;
        wr_data.lat = latitude;
        wr_data.lon = longitude;
        off_w  = {t_reg[31], t_reg} - {prev_reg.tm[31], prev_reg.tm};
        span_w = {rd_data.tm[31], rd_data.tm} - {prev_reg.tm[31], prev_reg.tm};
        is_exact   = rvalid_reg && (rd_data.tm == t_reg);
        is_bracket = rvalid_reg && (eval_reg != '0)
                   && ($signed(rd_data.tm) > $signed(t_reg))
                   && ($signed(prev_reg.tm) < $signed(t_reg));
    end

    tdi_track_mem #(.DEPTH(TRACK_DEPTH), .AW(AW)) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (issue_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    tdi_math u_math (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .job   (job_reg),
        .done  (math_done),
        .dev   (math_dev)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            issue_reg     <= '0;
            eval_reg      <= '0;
            rvalid_reg    <= 1'b0;
            tbase_reg     <= '0;
            qbase_reg     <= '0;
            qseen_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            start_reg     <= 1'b0;
            res_found_reg <= 1'b0;
        end
        else
        begin
            start_reg  <= (state_reg == S_SCAN) && (is_exact || is_bracket);
            rvalid_reg <= rd_en;
            if (out_valid_reg && !out_stall && (state_reg != S_RES))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (acc && !kind)
                    begin
                        if (wr_en)
                        begin
                            count_reg <= count_reg + CW'(1);
                            if (count_reg == '0)
                            begin
                                tbase_reg <= time_req;
                            end
                        end
                    end
                    else if (acc)
                    begin
                        issue_reg <= '0;
                        eval_reg  <= '0;
                        if (!qseen_reg)
                        begin
                            qbase_reg <= time_req;
                            qseen_reg <= 1'b1;
                        end
                        res_found_reg <= 1'b0;
                        if (count_reg == '0)
                        begin
                            state_reg <= S_RES;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (rd_en)
                    begin
                        issue_reg <= issue_reg + CW'(1);
                    end
                    if (is_exact || is_bracket)
                    begin
                        res_found_reg <= 1'b1;
                        state_reg     <= S_MATH;
                    end
                    else if (rvalid_reg)
                    begin
                        eval_reg <= eval_reg + CW'(1);
                        if (eval_reg == count_reg - CW'(1))
                        begin
                            state_reg <= S_RES;
                        end
                    end
                end
                S_MATH:
                begin
                    if (math_done)
                    begin
                        state_reg <= S_RES;
                    end
                end
                S_RES:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && acc && kind)
        begin
            t_reg    <= qseen_reg ? time_req - qbase_reg : 32'd0;
            qlat_reg <= latitude;
            qlon_reg <= longitude;
            res_dev_reg <= '0;
        end
        if (rvalid_reg)
        begin
            prev_reg <= rd_data;
        end
        if (state_reg == S_SCAN)
        begin
            job_reg.q_lat <= qlat_reg;
            job_reg.q_lon <= qlon_reg;
            job_reg.b_lat <= rd_data.lat;
            job_reg.b_lon <= rd_data.lon;
            if (is_exact)
            begin
                job_reg.a_lat <= rd_data.lat;
                job_reg.a_lon <= rd_data.lon;
                job_reg.off   <= 32'd0;
                job_reg.span  <= 32'd1;
            end
            else
            begin
                job_reg.a_lat <= prev_reg.lat;
                job_reg.a_lon <= prev_reg.lon;
                job_reg.off   <= off_w[31:0];
                job_reg.span  <= span_w[31:0];
            end
        end
        if (state_reg == S_MATH && math_done)
        begin
            res_dev_reg <= math_dev;
        end
        if (state_reg == S_RES && out_free)
        begin
            dev_reg   <= res_dev_reg;
            found_reg <= res_found_reg;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign deviation = dev_reg;
    assign found     = found_reg;

endmodule

>>> tb/tb_track_deviation_interpolator.sv
module tb_track_deviation_interpolator;
    import tdi_pkg::*;

    localparam int DEPTH      = 256;
    localparam int LAT_SPAN   = 377487360;
    localparam int LON_SPAN   = 754974720;
    localparam int STALL_CAP  = 20000;

    typedef struct {
        bit [30:0] dev;
        bit        hit;
    } deviation_t;

    class deviation_scoreboard;
        bit [31:0]          pt_time [DEPTH];
        logic signed [29:0] pt_lat  [DEPTH];
        logic signed [30:0] pt_lon  [DEPTH];
        int                 n_points;
        bit [31:0]          track_base;
        bit [31:0]          query_base;
        bit                 queried;
        deviation_t         pending [$];
        int                 errors;

        function new();
            n_points = 0;
            track_base = 0;
            query_base = 0;
            queried = 0;
            errors = 0;
        endfunction

        function longint unsigned root_floor(longint unsigned n);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n)
                b = b >> 2;
            while (b != 0)
            begin
                if (n >= r + b)
                begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        function void note_word(bit k, bit [31:0] tr, logic signed [29:0] la,
                                logic signed [30:0] lo);
            deviation_t e;
            longint t, ct, pt, span, off, alat, alon, dx, dy;
            longint unsigned sq, r;
            bit got;
            if (k == 1'b0)
            begin
                if (n_points >= DEPTH)
                    return;
                if (n_points == 0)
                    track_base = tr;
                pt_time[n_points] = tr - track_base;
                pt_lat[n_points]  = la;
                pt_lon[n_points]  = lo;
                n_points++;
                return;
            end
            if (!queried)
            begin
                query_base = tr;
                queried = 1;
            end
            t = longint'($signed(tr - query_base));
            got = 0;
            alat = 0;
            alon = 0;
            for (int i = 0; i < n_points && !got; i++)
            begin
                ct = longint'($signed(pt_time[i]));
                if (ct == t)
                begin
                    alat = pt_lat[i];
                    alon = pt_lon[i];
                    got = 1;
                end
                else if (i > 0)
                begin
                    pt = longint'($signed(pt_time[i-1]));
                    if (ct > t && pt < t)
                    begin
                        span = ct - pt;
                        off  = t - pt;
                        alat = longint'(pt_lat[i-1])
                             + ((longint'(pt_lat[i]) - longint'(pt_lat[i-1])) * off) / span;
                        alon = longint'(pt_lon[i-1])
                             + ((longint'(pt_lon[i]) - longint'(pt_lon[i-1])) * off) / span;
                        got = 1;
                    end
                end
            end
            e.dev = '0;
            e.hit = got;
            if (got)
            begin
                dx = longint'(la) - alat;
                dy = longint'(lo) - alon;
                if (dx < 0) dx = -dx;
                if (dy < 0) dy = -dy;
                sq = longint'(dx * dx) + longint'(dy * dy);
                r = root_floor(sq);
                e.dev = (r > 64'h7FFF_FFFF) ? DEV_MAX : r[30:0];
            end
            pending.push_back(e);
        endfunction

        function void check_result(bit [30:0] dev, bit hit);
            deviation_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result dev=%0d found=%0b", $time, dev, hit);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (e.hit !== hit)
            begin
                $display("%0t: found expected %0b actual %0b", $time, e.hit, hit);
                errors++;
            end
            if (e.dev !== dev)
            begin
                $display("%0t: deviation expected %0d actual %0d", $time, e.dev, dev);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        kind;
    logic [31:0] time_req;
    logic signed [29:0] latitude;
    logic signed [30:0] longitude;
    logic        out_valid;
    logic        out_stall;
    logic [30:0] deviation;
    logic        found;

    deviation_scoreboard sb;
    bit          calm;
    int          quiet_cycles;
    bit [31:0]   q0;
    bit [31:0]   t0;
    int unsigned last_rel;

    track_deviation_interpolator #(.TRACK_DEPTH(DEPTH)) DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .kind(kind), .time_req(time_req), .latitude(latitude), .longitude(longitude),
        .out_valid(out_valid), .out_stall(out_stall),
        .deviation(deviation), .found(found)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic int rand_lat();
        return int'($urandom_range(2 * LAT_SPAN, 0)) - LAT_SPAN;
    endfunction

    function automatic int rand_lon();
        return int'($urandom_range(2 * LON_SPAN, 0)) - LON_SPAN;
    endfunction

    task automatic send_word(bit k, bit [31:0] tr, int la, int lo);
        while (!calm && $urandom_range(99, 0) < 17)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= k;
        time_req  <= tr;
        latitude  <= la[29:0];
        longitude <= lo[30:0];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_word(k, tr, la[29:0], lo[30:0]);
    endtask

    task automatic load_at(int unsigned rel, int la, int lo);
        send_word(1'b0, t0 + rel, la, lo);
    endtask

    task automatic query_at(int unsigned rel, int la, int lo);
        send_word(1'b1, q0 + rel, la, lo);
    endtask

    // hold off until every outstanding result has drained
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        out_stall <= !calm && ($urandom_range(99, 0) < 17);
        if (rst_n && out_valid && !out_stall)
            sb.check_result(deviation, found);
        if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_CAP)
        begin
            $display("tb_track_deviation_interpolator failed");
            $finish;
        end
    end

    initial
    begin
        int r;
        int idx;
        sb = new();
        calm = 0;
        quiet_cycles = 0;
        rst_n = 0;
        in_valid = 0;
        kind = 0;
        time_req = 0;
        latitude = 0;
        longitude = 0;
        out_stall = 0;
        q0 = $urandom;
        t0 = $urandom;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, also fixes the query base
        query_at(0, 0, 0);
        load_at(0, LAT_SPAN, LON_SPAN);
        load_at(100, -LAT_SPAN, -LON_SPAN);
        load_at(200, 0, 0);
        load_at(300, 12345, -6789);
        load_at(300, -5, 7);
        load_at(1000, LAT_SPAN, -LON_SPAN);
        query_at(0, -LAT_SPAN, -LON_SPAN);   // first entry exact, widest distance
        query_at(50, 0, 0);
        query_at(100, -LAT_SPAN, -LON_SPAN);
        query_at(150, LAT_SPAN, LON_SPAN);
        query_at(300, 0, 0);                 // duplicate time: earliest wins
        query_at(301, 1, 1);
        query_at(999, -LAT_SPAN, LON_SPAN);
        query_at(1000, LAT_SPAN, -LON_SPAN);
        query_at(2000, 0, 0);                // past the end
        query_at(32'hFFFF_FFFB, 0, 0);       // negative relative time
        query_at(32'h8000_0000, 3, 3);
        last_rel = 1000;
        drain();

        for (int n = 0; n < 300; n++)
        begin
            calm = (n >= 150 && n < 230);
            if (n == 240)
                drain();
            r = $urandom_range(99, 0);
            if (r < 35)
            begin
                last_rel += $urandom_range(2000, 1);
                load_at(last_rel, rand_lat(), rand_lon());
            end
            else if (r < 38)
                send_word(1'b0, $urandom, rand_lat(), rand_lon());
            else if (r < 80)
                query_at($urandom_range(last_rel, 0), rand_lat(), rand_lon());
            else if (r < 93)
            begin
                idx = $urandom_range(sb.n_points - 1, 0);
                query_at(sb.pt_time[idx], rand_lat(), rand_lon());
            end
            else
                send_word(1'b1, $urandom, rand_lat(), rand_lon());
        end
        calm = 0;
        drain();

        // fill the table past capacity; the surplus loads are dropped
        while (sb.n_points < DEPTH)
        begin
            last_rel += $urandom_range(50, 1);
            load_at(last_rel, rand_lat(), rand_lon());
        end
        repeat (8)
            load_at(last_rel + $urandom_range(100, 1), rand_lat(), rand_lon());
        for (int n = 0; n < 14; n++)
            query_at($urandom_range(last_rel + 200, 0), rand_lat(), rand_lon());
        query_at(last_rel + 50, 0, 0);

        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (sb.errors == 0)
            $display("tb_track_deviation_interpolator passed");
        else
            $display("tb_track_deviation_interpolator failed");
        $finish;
    end

endmodule
